// ----- sv/bwcg_pkg.sv -----
// bwcg_pkg: shared types, codes and constants of the backplane window command generator
// used by bwcg_controller, bwcg_datapath and the top level; depends on nothing

`default_nettype none

package bwcg_pkg;

   localparam int MAX_BURST_BYTES_DEF = 2048;
   localparam int CHUNK_BYTES_DEF = 64;
   localparam int WINDOW_BITS_DEF = 15;

   localparam int ADDR_W = 32;
   localparam int LEN_W = 12;
   localparam int REG_W = 17;
   localparam int BYTE_W = 8;
   localparam int BYTES_W = 7;

   localparam int MAX_RESULTS = 40;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [ADDR_W-1:0] DATA_PORT = 32'h0000_8000;
   localparam logic [REG_W-1:0] WIN_REG0 = 17'h1000A;
   localparam logic [REG_W-1:0] WIN_REG1 = 17'h1000B;
   localparam logic [REG_W-1:0] WIN_REG2 = 17'h1000C;
   localparam logic [BYTES_W-1:0] READ_BYTES = 7'd4;

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_FORGET = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_WINDOW = 2'd0,
      KIND_READ   = 2'd1,
      KIND_WRITE  = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      SEL_WIN0,
      SEL_WIN1,
      SEL_WIN2,
      SEL_DATA,
      SEL_REJECT
   } out_sel_type;

   typedef struct packed {
      logic        latch_req;
      logic        clear_valid;
      logic        set_window;
      logic        calc_chunk;
      logic        step_chunk;
      logic        load_out;
      out_sel_type sel;
   } ctrl_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     bad;
      logic     hit;
      logic     emit_ok;
      logic     suppress;
      logic     more;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- sv/bwcg_controller.sv -----
// bwcg_controller: sequencing state machine of the window command generator
// depends on bwcg_pkg; drives bwcg_datapath through command and status structs

`default_nettype none

module bwcg_controller (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire bwcg_pkg::ctrl_status_type status,
   output bwcg_pkg::ctrl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_OPEN,
      S_WIN0,
      S_WIN1,
      S_WIN2,
      S_DATA
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.sel = bwcg_pkg::SEL_DATA;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch_req = req_valid;
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (status.mode)
               bwcg_pkg::MODE_READ: begin
                  state_in = S_OPEN;
               end
               bwcg_pkg::MODE_WRITE: begin
                  if (!status.bad) begin
                     state_in = S_OPEN;
                  end else if (status.emit_ok) begin
                     cmd.load_out = 1'b1;
                     cmd.sel = bwcg_pkg::SEL_REJECT;
                     state_in = S_IDLE;
                  end
               end
               bwcg_pkg::MODE_FORGET: begin
                  cmd.clear_valid = 1'b1;
                  state_in = S_IDLE;
               end
               bwcg_pkg::MODE_UNUSED: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_OPEN: begin
            cmd.calc_chunk = 1'b1;
            state_in = status.hit ? S_DATA : S_WIN0;
         end
         S_WIN0: begin
            cmd.sel = bwcg_pkg::SEL_WIN0;
            if (status.emit_ok) begin
               cmd.load_out = !status.suppress;
               state_in = S_WIN1;
            end
         end
         S_WIN1: begin
            cmd.sel = bwcg_pkg::SEL_WIN1;
            if (status.emit_ok) begin
               cmd.load_out = !status.suppress;
               state_in = S_WIN2;
            end
         end
         S_WIN2: begin
            cmd.sel = bwcg_pkg::SEL_WIN2;
            if (status.emit_ok) begin
               cmd.load_out = !status.suppress;
               cmd.set_window = 1'b1;
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            cmd.sel = bwcg_pkg::SEL_DATA;
            if (status.emit_ok) begin
               cmd.load_out = !status.suppress;
               if (status.mode == bwcg_pkg::MODE_WRITE && status.more) begin
                  cmd.step_chunk = 1'b1;
                  state_in = S_OPEN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

// ----- sv/bwcg_datapath.sv -----
// bwcg_datapath: request registers, window state, chunk arithmetic and result register
// depends on bwcg_pkg; commanded by bwcg_controller

`default_nettype none

module bwcg_datapath #(
   parameter int MAX_BURST_BYTES = bwcg_pkg::MAX_BURST_BYTES_DEF,
   parameter int CHUNK_BYTES = bwcg_pkg::CHUNK_BYTES_DEF,
   parameter int WINDOW_BITS = bwcg_pkg::WINDOW_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [bwcg_pkg::ADDR_W-1:0]   req_address,
   input  wire logic [bwcg_pkg::LEN_W-1:0]    req_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [bwcg_pkg::REG_W-1:0]         rsp_reg_address,
   output logic [bwcg_pkg::BYTE_W-1:0]        rsp_window_byte,
   output logic [bwcg_pkg::BYTES_W-1:0]       rsp_chunk_bytes,
   output logic                               rsp_last,
   input  wire bwcg_pkg::ctrl_cmd_type        cmd,
   output bwcg_pkg::ctrl_status_type          status
);

   localparam int AW = bwcg_pkg::ADDR_W;
   localparam int LW = bwcg_pkg::LEN_W;
   localparam int TAG_W = AW - WINDOW_BITS;
   localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
   localparam int CMP_W = (WINDOW_BITS + 1 > LW) ? WINDOW_BITS + 1 : LW;

   bwcg_pkg::mode_type mode_ff;
   logic [AW-1:0]      addr_ff;
   logic [LW-1:0]      len_ff;
   logic [CHUNK_W-1:0] chunk_ff;
   logic [CHUNK_W-1:0] chunk_in;
   logic [TAG_W-1:0]   window_base_ff;
   logic               window_valid_ff;
   logic [bwcg_pkg::CNT_W-1:0] count_ff;

   logic                          rsp_valid_ff;
   bwcg_pkg::kind_type            rsp_kind_ff;
   bwcg_pkg::kind_type            rsp_kind_in;
   logic [bwcg_pkg::REG_W-1:0]    rsp_reg_ff;
   logic [bwcg_pkg::REG_W-1:0]    rsp_reg_in;
   logic [bwcg_pkg::BYTE_W-1:0]   rsp_byte_ff;
   logic [bwcg_pkg::BYTE_W-1:0]   rsp_byte_in;
   logic [bwcg_pkg::BYTES_W-1:0]  rsp_bytes_ff;
   logic [bwcg_pkg::BYTES_W-1:0]  rsp_bytes_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;

   logic [TAG_W-1:0]       tag;
   logic [AW-1:0]          base32;
   logic [WINDOW_BITS-1:0] off;
   logic [AW-1:0]          data_addr;
   logic [CMP_W-1:0]       room;
   logic [CMP_W-1:0]       chunk_c;
   logic [AW-1:0]          chunk_wide;
   logic                   more;
   logic                   at_limit;
   logic                   write_mode;

   assign tag = addr_ff[AW-1:WINDOW_BITS];
   assign base32 = {tag, {WINDOW_BITS{1'b0}}};
   assign off = addr_ff[WINDOW_BITS-1:0];
   assign data_addr = {{TAG_W{1'b0}}, off} | bwcg_pkg::DATA_PORT;
   assign room = (CMP_W'(1) << WINDOW_BITS) - CMP_W'(off);
   assign chunk_wide = AW'(chunk_ff);
   assign more = (len_ff != LW'(chunk_ff));
   assign at_limit = (count_ff == bwcg_pkg::CNT_W'(bwcg_pkg::MAX_RESULTS - 1));
   assign write_mode = (mode_ff == bwcg_pkg::MODE_WRITE);

   // chunk: smallest of remaining length, chunk limit and room left in the window
   always_comb begin
      chunk_c = CMP_W'(len_ff);
      if (chunk_c > CMP_W'(CHUNK_BYTES)) begin
         chunk_c = CMP_W'(CHUNK_BYTES);
      end
      if (chunk_c > room) begin
         chunk_c = room;
      end
      chunk_in = chunk_c[CHUNK_W-1:0];
   end

   always_comb begin
      status.mode = mode_ff;
      status.bad = (len_ff == '0) || (len_ff[1:0] != 2'b00) || (addr_ff[1:0] != 2'b00)
                   || (AW'(len_ff) > AW'(MAX_BURST_BYTES));
      status.hit = window_valid_ff && (tag == window_base_ff);
      status.suppress = (count_ff == bwcg_pkg::CNT_W'(bwcg_pkg::MAX_RESULTS));
      status.emit_ok = status.suppress || !rsp_valid_ff || rsp_ready;
      status.more = more;
   end

   always_comb begin
      rsp_kind_in = bwcg_pkg::KIND_WINDOW;
      rsp_reg_in = '0;
      rsp_byte_in = '0;
      rsp_bytes_in = '0;
      rsp_last_in = at_limit;
      unique case (cmd.sel)
         bwcg_pkg::SEL_WIN0: begin
            rsp_reg_in = bwcg_pkg::WIN_REG0;
            rsp_byte_in = base32[15:8];
         end
         bwcg_pkg::SEL_WIN1: begin
            rsp_reg_in = bwcg_pkg::WIN_REG1;
            rsp_byte_in = base32[23:16];
         end
         bwcg_pkg::SEL_WIN2: begin
            rsp_reg_in = bwcg_pkg::WIN_REG2;
            rsp_byte_in = base32[31:24];
         end
         bwcg_pkg::SEL_DATA: begin
            rsp_reg_in = data_addr[bwcg_pkg::REG_W-1:0];
            if (write_mode) begin
               rsp_kind_in = bwcg_pkg::KIND_WRITE;
               rsp_bytes_in = chunk_wide[bwcg_pkg::BYTES_W-1:0];
               rsp_last_in = at_limit || !more;
            end else begin
               rsp_kind_in = bwcg_pkg::KIND_READ;
               rsp_bytes_in = bwcg_pkg::READ_BYTES;
               rsp_last_in = 1'b1;
            end
         end
         bwcg_pkg::SEL_REJECT: begin
            rsp_kind_in = bwcg_pkg::KIND_REJECT;
            rsp_last_in = 1'b1;
         end
         default: begin
            rsp_kind_in = bwcg_pkg::KIND_WINDOW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         mode_ff <= bwcg_pkg::mode_type'(req_mode);
         addr_ff <= req_address;
         len_ff <= req_length;
      end else if (cmd.step_chunk) begin
         addr_ff <= addr_ff + AW'(chunk_ff);
         len_ff <= len_ff - LW'(chunk_ff);
      end
      if (cmd.calc_chunk) begin
         chunk_ff <= chunk_in;
      end
      if (cmd.load_out) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_reg_ff <= rsp_reg_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_bytes_ff <= rsp_bytes_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff <= '0;
         window_valid_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_valid) begin
            window_valid_ff <= 1'b0;
         end else if (cmd.set_window) begin
            window_base_ff <= tag;
            window_valid_ff <= 1'b1;
         end
         if (cmd.latch_req) begin
            count_ff <= '0;
         end else if (cmd.load_out) begin
            count_ff <= count_ff + bwcg_pkg::CNT_W'(1);
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_reg_address = rsp_reg_ff;
   assign rsp_window_byte = rsp_byte_ff;
   assign rsp_chunk_bytes = rsp_bytes_ff;
   assign rsp_last = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bwcg_pkg::CNT_W'(bwcg_pkg::MAX_RESULTS))
      else $error("result count beyond limit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == bwcg_pkg::KIND_REJECT) |-> rsp_last_ff)
      else $error("reject without last");

   a_chunk_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.step_chunk |-> (chunk_ff != '0))
      else $error("empty chunk in write loop");

endmodule

`default_nettype wire

// ----- sv/backplane_window_command_generator.sv -----
// backplane_window_command_generator: top level joining controller and datapath
// depends on bwcg_pkg, bwcg_controller and bwcg_datapath

// Turns read, block write and forget requests into window register writes and data
// commands. One request is taken at a time; req_ready is high only while the sequencer
// waits for a request, and the last result may still be held in the output register
// then. A request passes a decode state, then per data command a chunk state, the
// three window register writes when the window has to be reopened, and the data
// command; a write loops back to the chunk state for each further chunk, and a reject,
// forget or unused mode ends at the decode state. The request transfer happens in the
// idle state. A result waits while the result register holds one not yet taken on
// rsp_ready, unless it is suppressed. The sequencer state machine and its single result
// register set this pace. Results past the fortieth of a request are dropped while the
// window state still follows them.

`default_nettype none

module backplane_window_command_generator #(
   parameter int MAX_BURST_BYTES = bwcg_pkg::MAX_BURST_BYTES_DEF,
   parameter int CHUNK_BYTES = bwcg_pkg::CHUNK_BYTES_DEF,
   parameter int WINDOW_BITS = bwcg_pkg::WINDOW_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [bwcg_pkg::ADDR_W-1:0]   req_address,
   input  wire logic [bwcg_pkg::LEN_W-1:0]    req_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [bwcg_pkg::REG_W-1:0]         rsp_reg_address,
   output logic [bwcg_pkg::BYTE_W-1:0]        rsp_window_byte,
   output logic [bwcg_pkg::BYTES_W-1:0]       rsp_chunk_bytes,
   output logic                               rsp_last
);

   bwcg_pkg::ctrl_cmd_type    cmd;
   bwcg_pkg::ctrl_status_type status;

   bwcg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bwcg_datapath #(
      .MAX_BURST_BYTES (MAX_BURST_BYTES),
      .CHUNK_BYTES     (CHUNK_BYTES),
      .WINDOW_BITS     (WINDOW_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_length      (req_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_reg_address (rsp_reg_address),
      .rsp_window_byte (rsp_window_byte),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for backplane_window_command_generator; a directed table of
// requests, then random ones, every result transfer checked against a model kept in the bench
// depends on bwcg_pkg and the block's RTL

`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W = bwcg_pkg::ADDR_W;
   localparam int LEN_W = bwcg_pkg::LEN_W;
   localparam int REG_W = bwcg_pkg::REG_W;
   localparam int BYTE_W = bwcg_pkg::BYTE_W;
   localparam int BYTES_W = bwcg_pkg::BYTES_W;
   localparam int WIN_BITS = bwcg_pkg::WINDOW_BITS_DEF;
   localparam int TAG_W = ADDR_W - WIN_BITS;
   localparam logic [ADDR_W-1:0] WIN_MASK = (32'd1 << WIN_BITS) - 32'd1;
   localparam int RANDOM_ITEMS = 240;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      bwcg_pkg::kind_type   kind;
      logic [REG_W-1:0]     reg_address;
      logic [BYTE_W-1:0]    window_byte;
      logic [BYTES_W-1:0]   chunk_bytes;
      logic                 last;
   } bus_cmd_type;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_RESULT,
      TYPED_RESULT
   } expect_src_type;

   typedef struct packed {
      bwcg_pkg::mode_type   mode;
      logic [ADDR_W-1:0]    address;
      logic [LEN_W-1:0]     length;
      expect_src_type       src;
      bus_cmd_type          typed;
   } stim_row_type;

   localparam bus_cmd_type NIL_CMD = '{bwcg_pkg::KIND_WINDOW, '0, '0, '0, 1'b0};
   localparam bus_cmd_type REJECT_CMD = '{bwcg_pkg::KIND_REJECT, '0, '0, '0, 1'b1};
   localparam bus_cmd_type TOP_READ_CMD = '{bwcg_pkg::KIND_READ, 17'h0FFFC, 8'h00, 7'd4, 1'b1};

   localparam int DIRECTED_ROWS = 20;

   stim_row_type directed [DIRECTED_ROWS] = '{
      '{bwcg_pkg::MODE_WRITE,  32'h0000_0000, 12'd0,    TYPED_RESULT, REJECT_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h0000_0000, 12'd6,    TYPED_RESULT, REJECT_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h0000_0000, 12'd2052, TYPED_RESULT, REJECT_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h0000_0002, 12'd4,    TYPED_RESULT, REJECT_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'hFFFF_FFFF, 12'd4095, TYPED_RESULT, REJECT_CMD},
      '{bwcg_pkg::MODE_READ,   32'h0000_0000, 12'd0,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_READ,   32'h0000_7FFC, 12'd4095, TYPED_RESULT, TOP_READ_CMD},
      '{bwcg_pkg::MODE_READ,   32'hFFFF_FFFF, 12'd0,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'hFFFF_FFC0, 12'd2048, BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_FORGET, 32'h0000_0000, 12'd0,    NO_RESULT,    NIL_CMD},
      '{bwcg_pkg::MODE_READ,   32'h0000_0000, 12'd0,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 12'd4095, NO_RESULT,    NIL_CMD},
      '{bwcg_pkg::MODE_READ,   32'h1234_5679, 12'd0,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h0000_7FE0, 12'd2048, BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h0001_0000, 12'd4,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h0001_0000, 12'd2048, BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'hABCD_0004, 12'd60,   BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_WRITE,  32'h7FFC_7FFC, 12'd8,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_READ,   32'h8000_0000, 12'd0,    BY_MODEL,     NIL_CMD},
      '{bwcg_pkg::MODE_FORGET, 32'hFFFF_FFFF, 12'd4095, NO_RESULT,    NIL_CMD}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_mode;
   logic [ADDR_W-1:0]    req_address;
   logic [LEN_W-1:0]     req_length;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_kind;
   logic [REG_W-1:0]     rsp_reg_address;
   logic [BYTE_W-1:0]    rsp_window_byte;
   logic [BYTES_W-1:0]   rsp_chunk_bytes;
   logic                 rsp_last;

   logic [TAG_W-1:0]     win_tag;
   bit                   win_open;
   bus_cmd_type          cmd_batch[$];
   bus_cmd_type          expected_cmds[$];
   logic [ADDR_W-1:0]    hot_bases[4];

   bit                   calm_tx;
   bit                   calm_rx;
   int                   errors = 0;
   int                   requests = 0;
   int                   cmds_checked = 0;
   int                   window_writes = 0;
   int                   rejects = 0;
   int unsigned          cycle_count = 0;

   backplane_window_command_generator uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .req_length      (req_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_reg_address (rsp_reg_address),
      .rsp_window_byte (rsp_window_byte),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   function automatic void add_cmd(bwcg_pkg::kind_type k, logic [REG_W-1:0] ra,
                                   logic [BYTE_W-1:0] wb, logic [BYTES_W-1:0] cb);
      bus_cmd_type c;
      if (cmd_batch.size() < bwcg_pkg::MAX_RESULTS) begin
         c.kind = k;
         c.reg_address = ra;
         c.window_byte = wb;
         c.chunk_bytes = cb;
         c.last = 1'b0;
         cmd_batch.push_back(c);
      end
   endfunction

   function automatic void open_window(logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] base;
      base = a & ~WIN_MASK;
      if (!win_open || a[ADDR_W-1:WIN_BITS] != win_tag) begin
         add_cmd(bwcg_pkg::KIND_WINDOW, bwcg_pkg::WIN_REG0, base[15:8], '0);
         add_cmd(bwcg_pkg::KIND_WINDOW, bwcg_pkg::WIN_REG1, base[23:16], '0);
         add_cmd(bwcg_pkg::KIND_WINDOW, bwcg_pkg::WIN_REG2, base[31:24], '0);
         win_tag = a[ADDR_W-1:WIN_BITS];
         win_open = 1'b1;
      end
   endfunction

   // fills cmd_batch with the bus commands one request turns into
   function automatic void predict_commands(bwcg_pkg::mode_type m, logic [ADDR_W-1:0] a,
                                            logic [LEN_W-1:0] l);
      logic [ADDR_W-1:0] cur;
      logic [ADDR_W-1:0] off;
      int unsigned left;
      int unsigned room;
      int unsigned chunk;
      bus_cmd_type tail;
      cmd_batch.delete();
      cur = a;
      left = l;
      case (m)
         bwcg_pkg::MODE_READ: begin
            open_window(a);
            add_cmd(bwcg_pkg::KIND_READ, REG_W'(bwcg_pkg::DATA_PORT | (a & WIN_MASK)), '0,
                    bwcg_pkg::READ_BYTES);
         end
         bwcg_pkg::MODE_WRITE: begin
            if (l == 0 || l[1:0] != 2'b00 || a[1:0] != 2'b00
                || l > bwcg_pkg::MAX_BURST_BYTES_DEF) begin
               add_cmd(bwcg_pkg::KIND_REJECT, '0, '0, '0);
            end else begin
               while (left != 0) begin
                  open_window(cur);
                  off = cur & WIN_MASK;
                  room = WIN_MASK + 1 - off;
                  chunk = (left < bwcg_pkg::CHUNK_BYTES_DEF) ? left : bwcg_pkg::CHUNK_BYTES_DEF;
                  if (chunk > room) begin
                     chunk = room;
                  end
                  add_cmd(bwcg_pkg::KIND_WRITE, REG_W'(bwcg_pkg::DATA_PORT | off), '0,
                          BYTES_W'(chunk));
                  cur = cur + chunk;
                  left = left - chunk;
               end
            end
         end
         bwcg_pkg::MODE_FORGET: begin
            win_open = 1'b0;
         end
         default: begin
         end
      endcase
      if (cmd_batch.size() > 0) begin
         tail = cmd_batch.pop_back();
         tail.last = 1'b1;
         cmd_batch.push_back(tail);
      end
   endfunction

   task automatic issue(bwcg_pkg::mode_type m, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l,
                        expect_src_type src, bus_cmd_type typed);
      int gap;
      gap = draw_wait(calm_tx);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_address <= a;
      req_length <= l;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_commands(m, a, l);
      case (src)
         BY_MODEL: begin
            foreach (cmd_batch[i]) expected_cmds.push_back(cmd_batch[i]);
         end
         TYPED_RESULT: begin
            expected_cmds.push_back(typed);
         end
         default: begin
         end
      endcase
      requests++;
      if ($urandom_range(0, 15) == 0) calm_tx = !calm_tx;
   endtask

   task automatic pick_request(output bwcg_pkg::mode_type m, output logic [ADDR_W-1:0] a,
                               output logic [LEN_W-1:0] l);
      int unsigned roll;
      int unsigned size_roll;
      logic [ADDR_W-1:0] off;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 6) begin
         off = ($urandom_range(0, 3) == 0) ? WIN_MASK - $urandom_range(0, 511) : $urandom;
         a = hot_bases[$urandom_range(0, 3)] | (off & WIN_MASK);
      end else begin
         a = $urandom;
      end
      l = LEN_W'($urandom);
      if (roll < 30) begin
         m = bwcg_pkg::MODE_READ;
      end else if (roll < 75) begin
         m = bwcg_pkg::MODE_WRITE;
         a[1:0] = 2'b00;
         size_roll = $urandom_range(0, 19);
         if (size_roll < 13) l = LEN_W'(4 * $urandom_range(1, 16));
         else if (size_roll < 19) l = LEN_W'(4 * $urandom_range(17, 128));
         else l = LEN_W'(bwcg_pkg::MAX_BURST_BYTES_DEF);
      end else if (roll < 87) begin
         m = bwcg_pkg::MODE_WRITE;
         case ($urandom_range(0, 3))
            0: l = '0;
            1: l = LEN_W'(4 * $urandom_range(0, 511) + $urandom_range(1, 3));
            2: l = LEN_W'($urandom_range(bwcg_pkg::MAX_BURST_BYTES_DEF + 1, 4095));
            default: begin
               l = LEN_W'(4 * $urandom_range(1, 16));
               a[1:0] = 2'($urandom_range(1, 3));
            end
         endcase
      end else if (roll < 95) begin
         m = bwcg_pkg::MODE_FORGET;
      end else begin
         m = bwcg_pkg::MODE_UNUSED;
      end
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   task automatic check_cmd();
      bus_cmd_type want;
      if (expected_cmds.size() == 0) begin
         errors++;
         $display("%0t: unexpected transfer, expected none, got kind %0d reg %h byte %h",
                  $time, rsp_kind, rsp_reg_address, rsp_window_byte);
         $display("%0t: unexpected transfer continued, bytes %0d last %0b",
                  $time, rsp_chunk_bytes, rsp_last);
      end else begin
         want = expected_cmds.pop_front();
         compare_field("kind", want.kind, rsp_kind);
         compare_field("reg_address", want.reg_address, rsp_reg_address);
         compare_field("window_byte", want.window_byte, rsp_window_byte);
         compare_field("chunk_bytes", want.chunk_bytes, rsp_chunk_bytes);
         compare_field("last", want.last, rsp_last);
         cmds_checked++;
         if (want.kind == bwcg_pkg::KIND_WINDOW) window_writes++;
         if (want.kind == bwcg_pkg::KIND_REJECT) rejects++;
      end
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_wait(calm_rx);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_cmd();
         if ($urandom_range(0, 15) == 0) calm_rx = !calm_rx;
      end
   end

   initial begin
      int done;
      bwcg_pkg::mode_type m;
      logic [ADDR_W-1:0] a;
      logic [LEN_W-1:0] l;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= bwcg_pkg::MODE_READ;
      req_address <= '0;
      req_length <= '0;
      win_tag = '0;
      win_open = 1'b0;
      hot_bases[0] = '0;
      hot_bases[1] = ~WIN_MASK;
      hot_bases[2] = $urandom & ~WIN_MASK;
      hot_bases[3] = $urandom & ~WIN_MASK;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         issue(directed[i].mode, directed[i].address, directed[i].length,
               directed[i].src, directed[i].typed);
      end
      done = 0;
      while (done < RANDOM_ITEMS) begin
         pick_request(m, a, l);
         issue(m, a, l, BY_MODEL, NIL_CMD);
         done++;
      end
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d requests (%0d from the table), %0d result transfers checked",
               requests, DIRECTED_ROWS, cmds_checked);
      $display("of those, %0d window register writes and %0d rejects; %0d errors",
               window_writes, rejects, errors);
      if (errors == 0) begin
         $display("** backplane_window_command_generator: PASSED **");
      end else begin
         $display("** backplane_window_command_generator: FAILED **");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles, %0d results still outstanding",
               $time, cycle_count, expected_cmds.size());
      $display("** backplane_window_command_generator: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
